[rtl/apsp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the all-pairs shortest path block.
// Has no dependencies; apsp_cell and all_pairs_shortest_path import it.
package apsp_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int DIST_W        = 32;
    localparam int WEIGHT_W      = 18;
    localparam int NODE_W        = 6;
    localparam int COUNT_W       = 7;
    // Widths that cover every legal MAX_NODES (up to 256).
    localparam int IDX_MAX_W     = 8;
    localparam int CNT_MAX_W     = 9;

    localparam logic [DIST_W-1:0] NO_EDGE = 32'd99999;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    // One element of a pivot row as it travels down the chain of cells.
    typedef struct packed {
        logic                 valid;
        logic [IDX_MAX_W-1:0] col;
        logic [DIST_W-1:0]    val;
    } strm_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                 preload;
        logic [IDX_MAX_W-1:0] via;
        logic [CNT_MAX_W-1:0] n;
        logic                 clr_en;
        logic [IDX_MAX_W-1:0] clr_addr;
        logic                 ld_en;
        logic [IDX_MAX_W-1:0] ld_row;
        logic [IDX_MAX_W-1:0] ld_col;
        logic [DIST_W-1:0]    ld_data;
        logic [IDX_MAX_W-1:0] rb_addr;
    } ctrl_t;

endpackage

[rtl/apsp_ram.sv]
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module apsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[rtl/apsp_cell.sv]
`timescale 1ns / 1ps
// One cell of the relaxation chain: owns one row of the distance matrix.
// Depends on apsp_pkg and apsp_ram.
module apsp_cell #(
    parameter int ROW       = 0,
    parameter int MAX_NODES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  apsp_pkg::ctrl_t       ctrl,
    input  apsp_pkg::strm_t       strm_in,
    output apsp_pkg::strm_t       strm_out,
    output logic [apsp_pkg::DIST_W-1:0] rd_data
);
    import apsp_pkg::*;

    localparam int IW = $clog2(MAX_NODES);

    logic                 s0_valid_reg;
    logic [IW-1:0]        s0_col_reg;
    logic [DIST_W-1:0]    s0_val_reg;
    logic [DIST_W-1:0]    a_reg;
    logic                 pre_q_reg;
    logic                 out_valid_reg;
    logic [IDX_MAX_W-1:0] out_col_reg;
    logic [DIST_W-1:0]    out_val_reg;

    logic              active;
    logic              is_via;
    logic [IW-1:0]     raddr_a;
    logic [DIST_W-1:0] rdata_a;
    logic [DIST_W-1:0] sum;
    logic [DIST_W-1:0] newv;
    logic              we;
    logic [IW-1:0]     waddr;
    logic [DIST_W-1:0] wdata;

    assign active  = int'(ctrl.n) > ROW;
    assign is_via  = ctrl.via == IDX_MAX_W'(ROW);
    assign raddr_a = ctrl.preload ? IW'(ctrl.via) : IW'(strm_in.col);

    // Candidate path through the pivot: own row's pivot entry plus pivot row entry.
    assign sum  = a_reg + s0_val_reg;
    assign newv = ($signed(sum) < $signed(rdata_a)) ? sum : rdata_a;

    always_comb
    begin
        we    = 1'b0;
        waddr = IW'(ctrl.clr_addr);
        wdata = NO_EDGE;
        priority if (ctrl.clr_en)
        begin
            we    = 1'b1;
            waddr = IW'(ctrl.clr_addr);
            wdata = (ctrl.clr_addr == IDX_MAX_W'(ROW)) ? '0 : NO_EDGE;
        end
        else if (ctrl.ld_en && ctrl.ld_row == IDX_MAX_W'(ROW))
        begin
            we    = 1'b1;
            waddr = IW'(ctrl.ld_col);
            wdata = ctrl.ld_data;
        end
        else if (s0_valid_reg && active)
        begin
            we    = 1'b1;
            waddr = s0_col_reg;
            wdata = newv;
        end
    end

    apsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_NODES)
    ) u_row_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (IW'(ctrl.rb_addr)),
        .rdata_b (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            pre_q_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= strm_in.valid;
            pre_q_reg     <= ctrl.preload;
            out_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_col_reg  <= IW'(strm_in.col);
        s0_val_reg  <= strm_in.val;
        out_col_reg <= IDX_MAX_W'(s0_col_reg);
        // The pivot's own row passes on its updated values to the rows below.
        out_val_reg <= is_via ? newv : s0_val_reg;
        if (pre_q_reg)
        begin
            a_reg <= rdata_a;
        end
        else if (s0_valid_reg && active && s0_col_reg == IW'(ctrl.via))
        begin
            a_reg <= newv;
        end
    end

    assign strm_out = {out_valid_reg, out_col_reg, out_val_reg};

endmodule

[rtl/all_pairs_shortest_path.sv]
`timescale 1ns / 1ps
// All-pairs shortest path (Floyd-Warshall) over a chain of MAX_NODES row cells.
// Loads and rejected items give their word in the cycle after acceptance; a read goes
// through ST_RD, a clear through the ST_CLEAR pass, a run through ST_PRE, ST_STREAM and
// ST_DRAIN per pivot as its row streams down the cell chain (n = 0 answers at once).
// One load per cycle while the result port accepts; a read holds off new items in ST_RD.
// Reset is asynchronous; a clearing pass follows. Depends on apsp_pkg, apsp_cell, apsp_ram.
module all_pairs_shortest_path #(
    parameter int MAX_NODES = apsp_pkg::MAX_NODES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: node_count.
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // origin[5:0], dest[11:6], weight[29:12], zero[31:30]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    // Result words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // distance[31:0]
    output logic [2:0]  m_axis_tuser    // unreachable[0], edge_rejected[1], done_res[2]
);
    import apsp_pkg::*;

    localparam int IW         = $clog2(MAX_NODES);
    localparam int CW         = $clog2(MAX_NODES + 1);
    localparam int DRAIN_LAST = 2 * MAX_NODES + 3;
    localparam int DW         = $clog2(DRAIN_LAST + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_PRE,
        ST_STREAM,
        ST_DRAIN
    } state_t;

    state_t             state_reg;
    logic [IW-1:0]      clr_reg;
    logic               clr_resp_reg;
    logic [IW-1:0]      via_reg;
    logic [IW-1:0]      col_reg;
    logic [DW-1:0]      drain_reg;
    logic               hd_valid_reg;
    logic [IW-1:0]      hd_col_reg;
    logic [IW-1:0]      rd_row_reg;
    logic [COUNT_W-1:0] node_count_reg;
    logic               m_valid_reg;
    logic [DIST_W-1:0]  m_data_reg;
    logic [2:0]         m_user_reg;

    logic [NODE_W-1:0]   origin;
    logic [NODE_W-1:0]   dest;
    logic [WEIGHT_W-1:0] weight;
    action_t             action;
    logic [CW-1:0]       n_eff;
    logic                ok;
    logic                accept;
    logic                out_ready;
    ctrl_t               ctrl;
    strm_t               chain [MAX_NODES+1];
    logic [DIST_W-1:0]   rdb [MAX_NODES];
    logic [DIST_W-1:0]   rd_word;

    assign origin = s_axis_tdata[5:0];
    assign dest   = s_axis_tdata[11:6];
    assign weight = s_axis_tdata[29:12];
    assign action = action_t'(s_axis_tuser);

    // Node count is saturated to the matrix size.
    assign n_eff = (int'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_reg);
    assign ok    = (int'(origin) < int'(n_eff)) && (int'(dest) < int'(n_eff));

    // An item is taken only in idle, and only once the result register can take its word.
    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        ctrl.preload  = (state_reg == ST_PRE);
        ctrl.via      = IDX_MAX_W'(via_reg);
        ctrl.n        = CNT_MAX_W'(n_eff);
        ctrl.clr_en   = (state_reg == ST_CLEAR);
        ctrl.clr_addr = IDX_MAX_W'(clr_reg);
        ctrl.ld_en    = accept && (action == ACT_LOAD) && ok;
        ctrl.ld_row   = IDX_MAX_W'(origin);
        ctrl.ld_col   = IDX_MAX_W'(dest);
        ctrl.ld_data  = {{(DIST_W - WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
        // The second read port serves the pivot row fetch during a run, reads otherwise.
        ctrl.rb_addr  = (state_reg == ST_STREAM) ? IDX_MAX_W'(col_reg) : IDX_MAX_W'(dest);
    end

    // The head of the chain carries the pivot row, read from the pivot's own cell.
    assign chain[0] = {hd_valid_reg, IDX_MAX_W'(hd_col_reg), rdb[via_reg]};

    for (genvar r = 0; r < MAX_NODES; r++)
    begin : g_cell
        apsp_cell #(
            .ROW       (r),
            .MAX_NODES (MAX_NODES)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .strm_in  (chain[r]),
            .strm_out (chain[r+1]),
            .rd_data  (rdb[r])
        );
    end

    assign rd_word = rdb[rd_row_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            clr_resp_reg   <= 1'b0;
            via_reg        <= '0;
            col_reg        <= '0;
            drain_reg      <= '0;
            hd_valid_reg   <= 1'b0;
            node_count_reg <= COUNT_W'(1);
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            hd_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (int'(clr_reg) == MAX_NODES - 1)
                    begin
                        clr_reg   <= '0;
                        state_reg <= ST_IDLE;
                        if (clr_resp_reg)
                        begin
                            clr_resp_reg <= 1'b0;
                            m_valid_reg  <= 1'b1;
                            m_data_reg   <= '0;
                            m_user_reg   <= 3'b100;
                        end
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (action)
                            ACT_CLEAR:
                            begin
                                clr_resp_reg <= 1'b1;
                                state_reg    <= ST_CLEAR;
                            end
                            ACT_LOAD:
                            begin
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= '0;
                                m_user_reg  <= ok ? 3'b100 : 3'b010;
                            end
                            ACT_RUN:
                            begin
                                if (n_eff == '0)
                                begin
                                    m_valid_reg <= 1'b1;
                                    m_data_reg  <= '0;
                                    m_user_reg  <= 3'b100;
                                end
                                else
                                begin
                                    via_reg   <= '0;
                                    state_reg <= ST_PRE;
                                end
                            end
                            ACT_READ:
                            begin
                                if (ok)
                                begin
                                    rd_row_reg <= IW'(origin);
                                    state_reg  <= ST_RD;
                                end
                                else
                                begin
                                    m_valid_reg <= 1'b1;
                                    m_data_reg  <= '0;
                                    m_user_reg  <= 3'b010;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_RD:
                begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= rd_word;
                    m_user_reg  <= {2'b00, rd_word == NO_EDGE};
                    state_reg   <= ST_IDLE;
                end
                ST_PRE:
                begin
                    // Every cell fetches its own entry in the pivot column this cycle.
                    col_reg   <= '0;
                    state_reg <= ST_STREAM;
                end
                ST_STREAM:
                begin
                    hd_valid_reg <= 1'b1;
                    hd_col_reg   <= col_reg;
                    col_reg      <= col_reg + 1'b1;
                    if (int'(col_reg) == int'(n_eff) - 1)
                    begin
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    // Wait until the last pivot word has left the final cell.
                    drain_reg <= drain_reg + 1'b1;
                    if (int'(drain_reg) == DRAIN_LAST)
                    begin
                        if (int'(via_reg) == int'(n_eff) - 1)
                        begin
                            via_reg     <= '0;
                            state_reg   <= ST_IDLE;
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= '0;
                            m_user_reg  <= 3'b100;
                        end
                        else
                        begin
                            via_reg   <= via_reg + 1'b1;
                            state_reg <= ST_PRE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // The pivot stream only flows while a run is fetching or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        hd_valid_reg |-> (state_reg == ST_STREAM || state_reg == ST_DRAIN))
        else $error("pivot stream active outside a run");

    // A clearing pass and an edge load never write the matrix together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.clr_en && ctrl.ld_en))
        else $error("clear and load collide");

    // Words are taken only in idle; this checks that the clearing pass ends there, counter at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && int'(clr_reg) == MAX_NODES - 1) |=>
        (state_reg == ST_IDLE && clr_reg == '0))
        else $error("clearing pass did not finish cleanly");

endmodule
